// ===== src/button_click_event_detector_macros.svh =====
// Assertion helpers used by the detector top level to check the design.
`ifndef BUTTON_CLICK_EVENT_DETECTOR_MACROS_SVH
`define BUTTON_CLICK_EVENT_DETECTOR_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define BCED_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bced check failed");

// Next-cycle implication.
`define BCED_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bced check failed");

`endif

// ===== src/bced_pkg.sv =====
`default_nettype none

package bced_pkg;

  localparam int NUM_KEYS_DEF   = 4;
  localparam int FIFO_DEPTH_DEF = 16;
  localparam int LEVEL_BITS     = 4;
  localparam int CFG_AW         = 4;

  localparam logic [15:0] COUNT_MAX         = 16'hFFFF;
  localparam logic [15:0] FILTER_PERIOD_RST = 16'd20;
  localparam logic [15:0] LONG_PERIOD_RST   = 16'd1500;
  localparam logic [15:0] DOUBLE_WINDOW_RST = 16'd300;

  localparam logic KIND_POP = 1'b1;

  typedef enum logic [1:0] {
    EV_SHORT        = 2'd0,
    EV_DOUBLE       = 2'd1,
    EV_LONG         = 2'd2,
    EV_LONG_RELEASE = 2'd3
  } ev_code_t;

  typedef struct packed {
    logic           is_pop;
    logic [LEVEL_BITS-1:0] levels;
  } cmd_t;

  typedef struct packed {
    logic [1:0] key;
    ev_code_t   code;
  } evt_t;

  typedef struct packed {
    logic valid;
    evt_t evt;
  } push_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic overflow;
  } fifo_st_t;

endpackage

`default_nettype wire

// ===== src/bced_front.sv =====
`default_nettype none

module bced_front import bced_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_kind,
  input  logic [LEVEL_BITS-1:0] in_key_levels,
  output logic                  cmd_valid,
  output cmd_t                  cmd,
  input  logic                  cmd_take
);

  // Two-entry command queue; pointers toggle between the slots.
  cmd_t       q_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r, cnt_nxt;
  logic       accept;

  assign in_stall  = cnt_r[1];
  assign accept    = in_valid && !in_stall;
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (accept && !cmd_take) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (!accept && cmd_take) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (accept) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (cmd_take) begin
        rd_ptr_r <= !rd_ptr_r;
      end
    end
  end

  // Classify the item as it is queued.
  always_ff @(posedge clk) begin
    if (accept) begin
      q_r[wr_ptr_r].is_pop <= (in_kind == KIND_POP);
      q_r[wr_ptr_r].levels <= in_key_levels;
    end
  end

endmodule

`default_nettype wire

// ===== src/bced_event_fifo.sv =====
`default_nettype none

module bced_event_fifo import bced_pkg::*; #(
  parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  push_t    push,
  input  logic     pop_req,
  output fifo_st_t fifo_st,
  output evt_t     rd_data
);

  localparam int IDX_W = $clog2(FIFO_DEPTH);
  localparam logic [IDX_W-1:0] LAST = IDX_W'(FIFO_DEPTH - 1);

  evt_t             mem [FIFO_DEPTH];
  evt_t             rd_data_r;
  logic [IDX_W-1:0] wr_idx_r, rd_idx_r;
  logic             wr_ph_r, rd_ph_r, ovf_r;
  logic             do_push;

  // Phase bits tell a full queue from an empty one at equal indexes.
  assign fifo_st.empty    = (wr_idx_r == rd_idx_r) && (wr_ph_r == rd_ph_r);
  assign fifo_st.full     = (wr_idx_r == rd_idx_r) && (wr_ph_r != rd_ph_r);
  assign fifo_st.overflow = ovf_r;
  assign rd_data          = rd_data_r;
  assign do_push          = push.valid && !fifo_st.full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_idx_r <= '0;
      rd_idx_r <= '0;
      wr_ph_r  <= 1'b0;
      rd_ph_r  <= 1'b0;
      ovf_r    <= 1'b0;
    end else begin
      if (push.valid && fifo_st.full) begin
        ovf_r <= 1'b1;
      end
      if (do_push) begin
        if (wr_idx_r == LAST) begin
          wr_idx_r <= '0;
          wr_ph_r  <= !wr_ph_r;
        end else begin
          wr_idx_r <= wr_idx_r + 1'b1;
        end
      end
      if (pop_req) begin
        if (rd_idx_r == LAST) begin
          rd_idx_r <= '0;
          rd_ph_r  <= !rd_ph_r;
        end else begin
          rd_idx_r <= rd_idx_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_idx_r] <= push.evt;
    end
    if (pop_req) begin
      rd_data_r <= mem[rd_idx_r];
    end
  end

endmodule

`default_nettype wire

// ===== src/bced_back.sv =====
`default_nettype none

module bced_back import bced_pkg::*; #(
  parameter int NUM_KEYS = NUM_KEYS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [15:0] filter_period,
  input  logic [15:0] long_period,
  input  logic [15:0] double_window,
  input  logic        cmd_valid,
  input  cmd_t        cmd,
  output logic        cmd_take,
  output push_t       push,
  output logic        pop_req,
  input  fifo_st_t    fifo_st,
  input  evt_t        rd_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_has_event,
  output logic [1:0]  out_key_index,
  output logic [1:0]  out_event_code,
  output logic        out_overflow
);

  localparam int KEY_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam logic [KEY_W-1:0] KEY_LAST = KEY_W'(NUM_KEYS - 1);

  typedef enum logic [2:0] {
    M_IDLE, M_PRESS_FILTER, M_CHECK_LONG, M_SHORT_REL_FILTER,
    M_CHECK_DOUBLE, M_DOUBLE_FILTER, M_DOUBLE_REL_FILTER, M_LONG_REL_FILTER
  } mode_t;

  typedef enum logic [1:0] {S_FETCH, S_TICK, S_POP} seq_t;

  typedef struct packed {
    mode_t       mode;
    logic [15:0] cnt;
    logic [15:0] saved;
    logic        push;
    ev_code_t    code;
  } step_t;

  function automatic step_t key_step(mode_t m, logic [15:0] c, logic [15:0] s,
                                     logic p, logic [15:0] fp, logic [15:0] lp,
                                     logic [15:0] dw);
    step_t       r;
    logic [15:0] c1;
    logic [16:0] sum;
    logic [15:0] rs;
    c1  = (c == COUNT_MAX) ? c : c + 16'd1;
    sum = {1'b0, c1} + {1'b0, s};
    rs  = sum[16] ? COUNT_MAX : sum[15:0];
    r.mode  = m;
    r.cnt   = c;
    r.saved = s;
    r.push  = 1'b0;
    r.code  = EV_SHORT;
    unique case (m)
      M_IDLE: begin
        if (p) begin
          r.mode = M_PRESS_FILTER;
          r.cnt  = '0;
        end
      end
      M_PRESS_FILTER: begin
        r.cnt = c1;
        if (c1 >= fp) begin
          r.mode = p ? M_CHECK_LONG : M_IDLE;
          if (p) r.cnt = '0;
        end
      end
      M_CHECK_LONG: begin
        r.cnt = c1;
        if (c1 < lp) begin
          if (!p) begin
            r.mode  = M_SHORT_REL_FILTER;
            r.saved = c1;
            r.cnt   = '0;
          end
        end else if (p) begin
          r.push = 1'b1;
          r.code = EV_LONG;
          r.mode = M_LONG_REL_FILTER;
          r.cnt  = '0;
        end
      end
      M_SHORT_REL_FILTER: begin
        r.cnt = c1;
        if (c1 >= fp) begin
          if (!p) begin
            r.mode = M_CHECK_DOUBLE;
            r.cnt  = '0;
          end else begin
            // bounce: resume long detection with the held time restored
            r.mode = M_CHECK_LONG;
            r.cnt  = rs;
          end
        end
      end
      M_CHECK_DOUBLE: begin
        r.cnt = c1;
        if (c1 < dw) begin
          if (p) begin
            r.mode  = M_DOUBLE_FILTER;
            r.cnt   = '0;
            r.saved = '0;
          end
        end else if (!p) begin
          r.push = 1'b1;
          r.code = EV_SHORT;
          r.mode = M_IDLE;
        end else begin
          r.mode = M_PRESS_FILTER;
          r.cnt  = '0;
        end
      end
      M_DOUBLE_FILTER: begin
        r.cnt = c1;
        if (c1 >= fp) begin
          if (p) begin
            r.push = 1'b1;
            r.code = EV_DOUBLE;
            r.mode = M_DOUBLE_REL_FILTER;
            r.cnt  = '0;
          end else begin
            r.mode = M_CHECK_DOUBLE;
            r.cnt  = rs;
          end
        end
      end
      M_DOUBLE_REL_FILTER: begin
        if (!p) begin
          r.cnt = c1;
          if (c1 >= fp) r.mode = M_IDLE;
        end
      end
      M_LONG_REL_FILTER: begin
        if (!p) begin
          r.cnt = c1;
          if (c1 >= fp) begin
            r.push = 1'b1;
            r.code = EV_LONG_RELEASE;
            r.mode = M_IDLE;
          end
        end
      end
    endcase
    return r;
  endfunction

  seq_t                  state_r;
  logic [KEY_W-1:0]      key_r;
  logic [LEVEL_BITS-1:0] levels_r;
  mode_t                 mode_r  [NUM_KEYS];
  logic [15:0]           cnt_r   [NUM_KEYS];
  logic [15:0]           saved_r [NUM_KEYS];
  logic                  out_valid_r, out_has_event_r, out_overflow_r;
  logic [1:0]            out_key_index_r, out_event_code_r;
  logic [NUM_KEYS-1:0]   lvl_vec;
  logic                  out_free;
  logic                  out_load;
  step_t                 step;

  for (genvar i = 0; i < NUM_KEYS; i++) begin : g_lvl
    if (i < LEVEL_BITS) begin : g_pin
      assign lvl_vec[i] = levels_r[i];
    end else begin : g_none
      assign lvl_vec[i] = 1'b1;
    end
  end

  assign step = key_step(mode_r[key_r], cnt_r[key_r], saved_r[key_r], !lvl_vec[key_r],
                         filter_period, long_period, double_window);

  assign out_free   = !out_valid_r || !out_stall;
  assign cmd_take   = (state_r == S_FETCH) && cmd_valid && (!cmd.is_pop || out_free);
  assign pop_req    = cmd_take && cmd.is_pop && !fifo_st.empty;
  assign push.valid = (state_r == S_TICK) && step.push;
  assign push.evt   = '{key: 2'(key_r), code: step.code};
  // load the result register on an empty pop or in S_POP for a pop from a non-empty queue
  assign out_load   = (state_r == S_POP) ||
                      ((state_r == S_FETCH) && cmd_take && cmd.is_pop && fifo_st.empty);

  assign out_valid      = out_valid_r;
  assign out_has_event  = out_has_event_r;
  assign out_key_index  = out_key_index_r;
  assign out_event_code = out_event_code_r;
  assign out_overflow   = out_overflow_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_FETCH;
      key_r       <= '0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < NUM_KEYS; k++) begin
        mode_r[k]  <= M_IDLE;
        cnt_r[k]   <= '0;
        saved_r[k] <= '0;
      end
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_FETCH: begin
          if (cmd_take && !cmd.is_pop) begin
            levels_r <= cmd.levels;
            key_r    <= '0;
            state_r  <= S_TICK;
          end else if (cmd_take && fifo_st.empty) begin
            out_has_event_r  <= 1'b0;
            out_key_index_r  <= '0;
            out_event_code_r <= '0;
            out_overflow_r   <= fifo_st.overflow;
          end else if (cmd_take) begin
            state_r <= S_POP;
          end
        end
        S_TICK: begin
          mode_r[key_r]  <= step.mode;
          cnt_r[key_r]   <= step.cnt;
          saved_r[key_r] <= step.saved;
          if (key_r == KEY_LAST) begin
            state_r <= S_FETCH;
          end else begin
            key_r <= key_r + 1'b1;
          end
        end
        S_POP: begin
          out_has_event_r  <= 1'b1;
          out_key_index_r  <= rd_data.key;
          out_event_code_r <= rd_data.code;
          out_overflow_r   <= fifo_st.overflow;
          state_r          <= S_FETCH;
        end
        default: state_r <= S_FETCH;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== src/button_click_event_detector.sv =====
// Channel   Dir  Handshake         Payload
// in        in   in_valid/in_stall in_kind, in_key_levels
// out       out  out_valid/out_stall out_has_event, out_key_index, out_event_code,
//                                  out_overflow
// cfg       in   APB psel/penable  paddr[3:2] selects filter, long, double window
//
// A tick item passes through the back end as a fetch step, then each key in turn
// through the single shared key-step unit. A pop on an empty queue loads the result
// register from S_FETCH; otherwise it passes through S_POP (registered event RAM read).
// Reset is synchronous, active low; it returns every key to idle and empties the queue.
// A two-entry command queue takes items, until both are full, while the back end works or
// the result register waits on out_stall; a pop also waits for that register to free up.
`default_nettype none

module button_click_event_detector import bced_pkg::*; #(
  parameter int NUM_KEYS   = NUM_KEYS_DEF,
  parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_kind,
  input  logic [LEVEL_BITS-1:0] in_key_levels,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_has_event,
  output logic [1:0]            out_key_index,
  output logic [1:0]            out_event_code,
  output logic                  out_overflow,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_AW-1:0]     paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

`include "button_click_event_detector_macros.svh"

  // register indexes on paddr[3:2]
  localparam logic [1:0] REG_FILTER = 2'd0;
  localparam logic [1:0] REG_LONG   = 2'd1;
  localparam logic [1:0] REG_DOUBLE = 2'd2;

  logic [15:0] filter_period_r, long_period_r, double_window_r;
  logic        cfg_wr;
  logic        cmd_valid, cmd_take, pop_req;
  cmd_t        cmd;
  push_t       push;
  fifo_st_t    fifo_st;
  evt_t        rd_data;

  // APB: no wait states; write lands on the access cycle.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filter_period_r <= FILTER_PERIOD_RST;
      long_period_r   <= LONG_PERIOD_RST;
      double_window_r <= DOUBLE_WINDOW_RST;
    end else if (cfg_wr) begin
      // drop writes to the unused fourth slot
      unique case (paddr[3:2])
        REG_FILTER: filter_period_r <= pwdata[15:0];
        REG_LONG:   long_period_r   <= pwdata[15:0];
        REG_DOUBLE: double_window_r <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_FILTER: prdata = {16'd0, filter_period_r};
      REG_LONG:   prdata = {16'd0, long_period_r};
      REG_DOUBLE: prdata = {16'd0, double_window_r};
      default:    prdata = '0;
    endcase
  end

  // Front end: accept and classify items into the command queue.
  bced_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_kind       (in_kind),
    .in_key_levels (in_key_levels),
    .cmd_valid     (cmd_valid),
    .cmd           (cmd),
    .cmd_take      (cmd_take)
  );

  // Back end: step the key machines one key a cycle, serve pops.
  bced_back #(
    .NUM_KEYS (NUM_KEYS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .filter_period  (filter_period_r),
    .long_period    (long_period_r),
    .double_window  (double_window_r),
    .cmd_valid      (cmd_valid),
    .cmd            (cmd),
    .cmd_take       (cmd_take),
    .push           (push),
    .pop_req        (pop_req),
    .fifo_st        (fifo_st),
    .rd_data        (rd_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_has_event  (out_has_event),
    .out_key_index  (out_key_index),
    .out_event_code (out_event_code),
    .out_overflow   (out_overflow)
  );

  // Event queue; full pushes are dropped and flagged.
  bced_event_fifo #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .pop_req (pop_req),
    .fifo_st (fifo_st),
    .rd_data (rd_data)
  );

  `BCED_ASSERT_IMP(a_pop_not_empty, pop_req, !fifo_st.empty)
  `BCED_ASSERT_NEXT(a_drop_sets_overflow, push.valid && fifo_st.full, fifo_st.overflow)
  `BCED_ASSERT_NEXT(a_overflow_sticky, fifo_st.overflow, fifo_st.overflow)
  `BCED_ASSERT_IMP(a_pop_needs_slot, cmd_take && cmd.is_pop, !out_valid || !out_stall)

endmodule

`default_nettype wire
